// ----- rtl/bps_pkg.sv -----
// Shared types, codes and type-word tables for the bracketed packet scanner.
package bps_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TOTAL_W     = 16;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [3:0] LEN_PUBKEY  = 4'd6;
    localparam logic [3:0] LEN_KEYPAIR = 4'd7;
    localparam logic [3:0] LEN_PRIVKEY = 4'd7;
    localparam logic [3:0] LEN_MAX     = 4'd15;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        ROLE_NONE = 2'd0,
        ROLE_TYPE = 2'd1,
        ROLE_ARGS = 2'd2,
        ROLE_BODY = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        KIND_PUBKEY  = 2'd0,
        KIND_KEYPAIR = 2'd1,
        KIND_PRIVKEY = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              is_letter;
        logic              is_blank;
        logic              is_open;
        logic              is_close;
        logic              is_e;
        logic              is_n;
        logic              is_d;
    } t_cls;

    function automatic logic [BYTE_W-1:0] kind_char(input logic [1:0] k,
                                                    input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        c = '0;
        case (k)
            2'd0: begin
                case (idx)
                    4'd0: c = 8'h70;
                    4'd1: c = 8'h75;
                    4'd2: c = 8'h62;
                    4'd3: c = 8'h6B;
                    4'd4: c = 8'h65;
                    4'd5: c = 8'h79;
                    default: c = '0;
                endcase
            end
            2'd1: begin
                case (idx)
                    4'd0: c = 8'h6B;
                    4'd1: c = 8'h65;
                    4'd2: c = 8'h79;
                    4'd3: c = 8'h70;
                    4'd4: c = 8'h61;
                    4'd5: c = 8'h69;
                    4'd6: c = 8'h72;
                    default: c = '0;
                endcase
            end
            2'd2: begin
                case (idx)
                    4'd0: c = 8'h70;
                    4'd1: c = 8'h72;
                    4'd2: c = 8'h69;
                    4'd3: c = 8'h76;
                    4'd4: c = 8'h6B;
                    4'd5: c = 8'h65;
                    4'd6: c = 8'h79;
                    default: c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] match_flags(input logic [2:0]        flags,
                                               input logic [3:0]        idx,
                                               input logic [BYTE_W-1:0] c);
        logic [2:0] f;
        f = flags;
        for (int k = 0; k < 3; k++) begin
            if (kind_char(2'(k), idx) != c) begin
                f[k] = 1'b0;
            end
        end
        return f;
    endfunction

    function automatic t_kind pick_kind(input logic [2:0] flags,
                                        input logic [3:0] len);
        t_kind r;
        r = KIND_UNKNOWN;
        if (flags[0] && len == LEN_PUBKEY) begin
            r = KIND_PUBKEY;
        end else if (flags[1] && len == LEN_KEYPAIR) begin
            r = KIND_KEYPAIR;
        end else if (flags[2] && len == LEN_PRIVKEY) begin
            r = KIND_PRIVKEY;
        end
        return r;
    endfunction

endpackage

// ----- rtl/bps_front.sv -----
// Front stage: takes bytes, classifies them and pushes them into the queue.
module bps_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bps_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_full,
    output logic                        o_push,
    output bps_pkg::t_cls               o_cls
);
    import bps_pkg::*;

    logic  r_valid, n_valid;
    t_cls  r_cls, n_cls;
    logic  accept;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign accept  = i_valid && !o_stall;
    assign o_cls   = r_cls;

    always_comb begin
        n_cls           = r_cls;
        n_valid         = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid         = 1'b1;
            n_cls.ch        = i_in_byte;
            n_cls.is_letter = (i_in_byte >= 8'h41 && i_in_byte <= 8'h5A) ||
                              (i_in_byte >= 8'h61 && i_in_byte <= 8'h7A);
            n_cls.is_blank  = (i_in_byte == CH_SP) || (i_in_byte == CH_TAB) ||
                              (i_in_byte == CH_LF) || (i_in_byte == CH_CR);
            n_cls.is_open   = (i_in_byte == CH_OPEN);
            n_cls.is_close  = (i_in_byte == CH_CLOSE);
            n_cls.is_e      = (i_in_byte == CH_E);
            n_cls.is_n      = (i_in_byte == CH_N);
            n_cls.is_d      = (i_in_byte == CH_D);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cls <= n_cls;
    end

endmodule

// ----- rtl/bps_queue.sv -----
// Short queue of classified bytes between the front and the scanner.
module bps_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bps_pkg::t_cls i_cls,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output bps_pkg::t_cls o_cls
);
    import bps_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_cls      = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue fill out of range");

endmodule

// ----- rtl/bps_back.sv -----
// Back stage: packet scanner state machine, counter and output register.
module bps_back #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_nonempty,
    input  bps_pkg::t_cls                i_cls,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_byte_role,
    output logic                         o_discard,
    output logic                         o_packet_done,
    output logic [1:0]                   o_packet_kind,
    output logic [bps_pkg::TOTAL_W-1:0]  o_accepted_total
);
    import bps_pkg::*;

    typedef enum logic [10:0] {
        S_SKIP  = 11'b000_0000_0001,
        S_OPEN  = 11'b000_0000_0010,
        S_TYPE  = 11'b000_0000_0100,
        S_FTYPE = 11'b000_0000_1000,
        S_ARGS  = 11'b000_0001_0000,
        S_FARGS = 11'b000_0010_0000,
        S_BODY  = 11'b000_0100_0000,
        S_E1    = 11'b000_1000_0000,
        S_E2    = 11'b001_0000_0000,
        S_E3    = 11'b010_0000_0000,
        S_E4    = 11'b100_0000_0000
    } t_state;

    t_state                 r_state, n_state;
    logic [2:0]             r_flags, n_flags;
    logic [3:0]             r_len, n_len;
    t_kind                  r_kind, n_kind;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic                   r_out_valid;
    t_role                  r_role;
    logic                   r_discard;
    logic                   r_done;
    t_kind                  r_pkind;
    logic [TOTAL_W-1:0]     r_total;

    t_role                  role;
    logic                   done;
    t_kind                  pkind;
    logic                   from_skip;
    logic                   discard;
    logic                   take;

    assign take  = i_q_nonempty && (!r_out_valid || !i_stall);
    assign o_pop = take;

    always_comb begin
        n_state   = S_SKIP;
        n_flags   = r_flags;
        n_len     = r_len;
        n_kind    = r_kind;
        n_count   = r_count;
        role      = ROLE_NONE;
        done      = 1'b0;
        pkind     = KIND_PUBKEY;
        from_skip = 1'b0;
        case (r_state)
            S_OPEN: begin
                n_flags = 3'b111;
                n_len   = '0;
                if (i_cls.is_letter) begin
                    n_flags = match_flags(3'b111, 4'd0, i_cls.ch);
                    n_len   = 4'd1;
                    role    = ROLE_TYPE;
                    n_state = S_TYPE;
                end
            end
            S_TYPE: begin
                if (i_cls.is_letter) begin
                    n_flags = match_flags(r_flags, r_len, i_cls.ch);
                    n_len   = (r_len != LEN_MAX) ? r_len + 4'd1 : r_len;
                    role    = ROLE_TYPE;
                    n_state = S_TYPE;
                end else if (i_cls.is_blank) begin
                    n_kind  = pick_kind(r_flags, r_len);
                    n_state = S_FTYPE;
                end
            end
            S_FTYPE: begin
                if (i_cls.is_blank) begin
                    n_state = S_FTYPE;
                end else if (!i_cls.is_close) begin
                    role    = ROLE_ARGS;
                    n_state = S_ARGS;
                end
            end
            S_ARGS: begin
                if (i_cls.is_close) begin
                    n_state = S_FARGS;
                end else begin
                    role    = ROLE_ARGS;
                    n_state = S_ARGS;
                end
            end
            S_FARGS: begin
                if (!i_cls.is_open && !i_cls.is_close) begin
                    role    = ROLE_BODY;
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                if (i_cls.is_open) begin
                    n_state = S_E1;
                end else if (!i_cls.is_close) begin
                    role    = ROLE_BODY;
                    n_state = S_BODY;
                end
            end
            S_E1: begin
                n_state = i_cls.is_e ? S_E2 : S_SKIP;
            end
            S_E2: begin
                n_state = i_cls.is_n ? S_E3 : S_SKIP;
            end
            S_E3: begin
                n_state = i_cls.is_d ? S_E4 : S_SKIP;
            end
            S_E4: begin
                if (i_cls.is_close) begin
                    done  = 1'b1;
                    pkind = r_kind;
                    if (r_kind != KIND_UNKNOWN && r_count != '1) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                from_skip = 1'b1;
                if (i_cls.is_open) begin
                    n_state = S_OPEN;
                end
            end
        endcase
        discard = !from_skip && (n_state == S_SKIP) && !done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SKIP;
            r_flags     <= 3'b111;
            r_len       <= '0;
            r_kind      <= KIND_UNKNOWN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_state <= n_state;
                r_flags <= n_flags;
                r_len   <= n_len;
                r_kind  <= n_kind;
                r_count <= n_count;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_role    <= role;
            r_discard <= discard;
            r_done    <= done;
            r_pkind   <= pkind;
            r_total   <= TOTAL_W'(n_count);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_byte_role      = r_role;
    assign o_discard        = r_discard;
    assign o_packet_done    = r_done;
    assign o_packet_kind    = r_pkind;
    assign o_accepted_total = r_total;

    a_done_no_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> !r_discard)
        else $error("completed request also flagged as discarded");

    a_done_to_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && done) |=> (r_state == S_SKIP))
        else $error("scanner not back to skipping after completion");

    a_type_role_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && role == ROLE_TYPE) |=> (r_state == S_TYPE))
        else $error("type letter without type state");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("packet counter went backwards");

endmodule

// ----- rtl/bracketed_packet_scanner.sv -----
// Top level of the bracketed packet scanner: front, queue and scanner back end.
// Scans a byte stream for "[type args]body[end]" packets and returns one tagged
// request per input byte, in order. One byte enters per clock when the output is
// not stalled; a byte passes the front register, a four-entry queue and the
// scanner's output register in that order. The scanner updates its state once
// per byte taken, which sets the sustained rate of one byte per clock; the queue
// absorbs up to four bytes (plus one in the front register) while the output
// side is stalled.
module bracketed_packet_scanner #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bps_pkg::BYTE_W-1:0]   i_in_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_byte_role,
    output logic                         o_discard,
    output logic                         o_packet_done,
    output logic [1:0]                   o_packet_kind,
    output logic [bps_pkg::TOTAL_W-1:0]  o_accepted_total
);
    import bps_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  nonempty;
    t_cls  front_cls;
    t_cls  queue_cls;

    bps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_push    (push),
        .o_cls     (front_cls)
    );

    bps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cls      (front_cls),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_cls      (queue_cls)
    );

    bps_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_nonempty     (nonempty),
        .i_cls            (queue_cls),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_byte_role      (o_byte_role),
        .o_discard        (o_discard),
        .o_packet_done    (o_packet_done),
        .o_packet_kind    (o_packet_kind),
        .o_accepted_total (o_accepted_total)
    );

endmodule
